@@ rtl/tun_pkg.sv @@
`timescale 1ns / 1ps
// tun_pkg: widths, constants and queue entry type for the triangle unit normal block.
// No dependencies.
package tun_pkg;
  localparam int CW    = 16;
  localparam int FW    = 14;
  localparam int EW    = CW + 1;
  localparam int PW    = 2 * EW;
  localparam int MW    = PW - 1;
  localparam int QW    = 2 * MW;
  localparam int SW    = QW + 2;
  localparam int UW    = FW + 2;
  localparam int OW    = FW + 2;
  localparam int RW    = SW + 2 * UW;
  localparam int PRW   = SW + UW;
  localparam int NL    = 3;
  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  typedef logic [2:0][2:0][CW-1:0] tun_vtx_t;

  typedef struct packed {
    logic [NL-1:0][QW-1:0] sq;
    logic [NL-1:0]         neg;
    logic [SW-1:0]         s;
    logic                  deg;
  } tun_item_t;
endpackage

@@ rtl/tun_front.sv @@
`timescale 1ns / 1ps
// tun_front: edges, cross product, squared components and squared length.
// Depends on tun_pkg.
module tun_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tun_pkg::tun_vtx_t  vtx,
  input  logic               q_full,
  output logic               push,
  output tun_pkg::tun_item_t item
);
  import tun_pkg::*;

  logic [3:0] v_r;
  logic en;
  logic signed [NL-1:0][EW-1:0] e1_r, e2_r;
  logic signed [NL-1:0][PW-1:0] pa_r, pb_r;
  logic [NL-1:0][MW-1:0] mag_r;
  logic [NL-1:0] neg2_r, neg3_r;
  logic [NL-1:0][QW-1:0] sq_r;
  logic signed [NL-1:0][EW-1:0] e1_nxt, e2_nxt;
  logic signed [NL-1:0][PW-1:0] pa_nxt, pb_nxt, c;
  logic [NL-1:0][MW-1:0] mag_nxt;
  logic [NL-1:0] neg_nxt;
  logic [SW-1:0] s;

  assign en       = !(v_r[3] && q_full);
  assign in_ready = en;
  assign push     = v_r[3] && !q_full;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      e1_nxt[i] = $signed({vtx[2][i][CW-1], vtx[2][i]}) - $signed({vtx[0][i][CW-1], vtx[0][i]});
      e2_nxt[i] = $signed({vtx[1][i][CW-1], vtx[1][i]}) - $signed({vtx[0][i][CW-1], vtx[0][i]});
    end
    for (int i = 0; i < NL; i++) begin
      pa_nxt[i] = $signed(e1_r[(i + 1) % 3]) * $signed(e2_r[(i + 2) % 3]);
      pb_nxt[i] = $signed(e1_r[(i + 2) % 3]) * $signed(e2_r[(i + 1) % 3]);
      c[i]      = $signed(pa_r[i]) - $signed(pb_r[i]);
      neg_nxt[i] = c[i][PW-1];
      mag_nxt[i] = neg_nxt[i] ? MW'(-c[i]) : MW'(c[i]);
    end
    s = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
  end

  assign item.sq  = sq_r;
  assign item.neg = neg3_r;
  assign item.s   = s;
  assign item.deg = (s == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r   <= e1_nxt;
      e2_r   <= e2_nxt;
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      mag_r  <= mag_nxt;
      neg2_r <= neg_nxt;
      neg3_r <= neg2_r;
      for (int i = 0; i < NL; i++) begin
        sq_r[i] <= mag_r[i] * mag_r[i];
      end
    end
  end
endmodule

@@ rtl/tun_queue.sv @@
`timescale 1ns / 1ps
// tun_queue: short FIFO between the front and the normalizing back end.
// Depends on tun_pkg.
module tun_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tun_pkg::tun_item_t wr_item,
  output logic               full,
  input  logic               pop,
  output tun_pkg::tun_item_t rd_item,
  output logic               empty
);
  import tun_pkg::*;

  tun_item_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_item = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wr_item;
  end
endmodule

@@ rtl/tun_back.sv @@
`timescale 1ns / 1ps
// tun_back: bit-serial pipelined search of the rounded normalized components.
// Depends on tun_pkg.
module tun_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  tun_pkg::tun_item_t       rd_item,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [tun_pkg::OW-1:0]   out_normal_x,
  output logic [tun_pkg::OW-1:0]   out_normal_y,
  output logic [tun_pkg::OW-1:0]   out_normal_z,
  output logic                     out_degenerate
);
  import tun_pkg::*;

  logic en;
  logic [UW:0] v_r;
  logic [UW:0][SW-1:0] s_r;
  logic [UW:0] deg_r;
  logic [UW:0][NL-1:0] neg_r;
  logic [UW:0][NL-1:0][RW-1:0] r_r, q_r, q_nxt;
  logic [UW:0][NL-1:0][PRW-1:0] p_r, p_nxt;
  logic [UW:0][NL-1:0][UW-1:0] u_r, u_nxt;
  logic [UW-1:0][NL-1:0][RW-1:0] trial;
  logic [NL-1:0][OW-1:0] res;
  logic [NL-1:0][UW:0] nfull;
  logic out_valid_r;
  logic [NL-1:0][OW-1:0] out_r;
  logic out_deg_r;

  assign en  = !(out_valid_r && !out_ready);
  assign pop = en && !q_empty;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      q_nxt[0][l] = '0;
      p_nxt[0][l] = '0;
      u_nxt[0][l] = '0;
    end
    for (int k = 0; k < UW; k++) begin
      for (int l = 0; l < NL; l++) begin
        trial[k][l] = q_r[k][l] + (RW'(p_r[k][l]) << (UW - k))
                      + (RW'(s_r[k]) << (2 * (UW - 1 - k)));
        if (trial[k][l] <= r_r[k][l]) begin
          q_nxt[k+1][l] = trial[k][l];
          p_nxt[k+1][l] = p_r[k][l] + (PRW'(s_r[k]) << (UW - 1 - k));
          u_nxt[k+1][l] = u_r[k][l] | (UW'(1) << (UW - 1 - k));
        end else begin
          q_nxt[k+1][l] = q_r[k][l];
          p_nxt[k+1][l] = p_r[k][l];
          u_nxt[k+1][l] = u_r[k][l];
        end
      end
    end
    for (int l = 0; l < NL; l++) begin
      nfull[l] = (UW+1)'(u_r[UW][l]) + (UW+1)'(1);
      if (deg_r[UW]) res[l] = '0;
      else if (neg_r[UW][l]) res[l] = OW'(-nfull[l][UW:1]);
      else res[l] = OW'(nfull[l][UW:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[UW-1:0], !q_empty};
      out_valid_r <= v_r[UW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0]   <= rd_item.s;
      deg_r[0] <= rd_item.deg;
      neg_r[0] <= rd_item.neg;
      for (int l = 0; l < NL; l++) begin
        r_r[0][l] <= RW'(rd_item.sq[l]) << (2 * FW + 2);
      end
      q_r[0] <= q_nxt[0];
      p_r[0] <= p_nxt[0];
      u_r[0] <= u_nxt[0];
      for (int k = 1; k <= UW; k++) begin
        s_r[k]   <= s_r[k-1];
        deg_r[k] <= deg_r[k-1];
        neg_r[k] <= neg_r[k-1];
        r_r[k]   <= r_r[k-1];
        q_r[k]   <= q_nxt[k];
        p_r[k]   <= p_nxt[k];
        u_r[k]   <= u_nxt[k];
      end
      out_r     <= res;
      out_deg_r <= deg_r[UW];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = out_r[0];
  assign out_normal_y   = out_r[1];
  assign out_normal_z   = out_r[2];
  assign out_degenerate = out_deg_r;
endmodule

@@ rtl/triangle_unit_normal_top.sv @@
`timescale 1ns / 1ps
// triangle_unit_normal_top: unit face normal of a triangle, Q1.14 output.
// Throughput: one transaction per cycle while out_ready does not stall the pipeline;
// path from the accepting edge to out_valid: 4 cross product front stages, the
// 4-entry queue, 17 normalizing search stages and the output register.
// Synchronous active-low reset empties all pipelines and the queue.
module triangle_unit_normal_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [tun_pkg::CW-1:0] in_vertex0_x,
  input  logic [tun_pkg::CW-1:0] in_vertex0_y,
  input  logic [tun_pkg::CW-1:0] in_vertex0_z,
  input  logic [tun_pkg::CW-1:0] in_vertex1_x,
  input  logic [tun_pkg::CW-1:0] in_vertex1_y,
  input  logic [tun_pkg::CW-1:0] in_vertex1_z,
  input  logic [tun_pkg::CW-1:0] in_vertex2_x,
  input  logic [tun_pkg::CW-1:0] in_vertex2_y,
  input  logic [tun_pkg::CW-1:0] in_vertex2_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [tun_pkg::OW-1:0] out_normal_x,
  output logic [tun_pkg::OW-1:0] out_normal_y,
  output logic [tun_pkg::OW-1:0] out_normal_z,
  output logic                   out_degenerate
);
  import tun_pkg::*;

  tun_vtx_t  vtx;
  tun_item_t wr_item, rd_item;
  logic push, pop, q_full, q_empty;

  assign vtx[0][0] = in_vertex0_x;
  assign vtx[0][1] = in_vertex0_y;
  assign vtx[0][2] = in_vertex0_z;
  assign vtx[1][0] = in_vertex1_x;
  assign vtx[1][1] = in_vertex1_y;
  assign vtx[1][2] = in_vertex1_z;
  assign vtx[2][0] = in_vertex2_x;
  assign vtx[2][1] = in_vertex2_y;
  assign vtx[2][2] = in_vertex2_z;

  tun_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .vtx(vtx),
    .q_full(q_full), .push(push), .item(wr_item)
  );

  tun_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wr_item(wr_item), .full(q_full),
    .pop(pop), .rd_item(rd_item), .empty(q_empty)
  );

  tun_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .rd_item(rd_item), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_normal_x(out_normal_x),
    .out_normal_y(out_normal_y), .out_normal_z(out_normal_z),
    .out_degenerate(out_degenerate)
  );
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench: checks triangle_unit_normal_top against an exact integer model of the
// unit face normal, using directed triangles and then random valid/ready traffic.
// Depends on rtl/tun_pkg.sv and rtl/triangle_unit_normal_top.sv.
module testbench;
  import tun_pkg::*;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    logic [OW-1:0] nx;
    logic [OW-1:0] ny;
    logic [OW-1:0] nz;
    logic          deg;
  } normal_t;

  typedef struct {
    coord_t  v [9];
    bit      known;
    normal_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CW-1:0] in_v [9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OW-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate;

  normal_t expected_normals [$];
  int mismatches = 0;
  int triangles_sent = 0;
  int normals_seen = 0;
  int degenerate_seen = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;

  initial for (int i = 0; i < 9; i++) in_v[i] = '0;

  always #5 clk = ~clk;

  triangle_unit_normal_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vertex0_x(in_v[0]), .in_vertex0_y(in_v[1]), .in_vertex0_z(in_v[2]),
    .in_vertex1_x(in_v[3]), .in_vertex1_y(in_v[4]), .in_vertex1_z(in_v[5]),
    .in_vertex2_x(in_v[6]), .in_vertex2_y(in_v[7]), .in_vertex2_z(in_v[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_degenerate(out_degenerate)
  );

  // largest n with (2n-1)^2 * s <= c^2 * 4^(F+1), i.e. round(|c| * 2^F / sqrt(s))
  function automatic logic [OW-1:0] scaled_component(input longint c,
                                                     input logic [127:0] s);
    logic [127:0] mag, rhs, odd, lhs;
    longint lo, hi, mid;
    mag = (c < 0) ? -c : c;
    rhs = (mag * mag) << (2 * FW + 2);
    lo = 0;
    hi = 1 << FW;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 2 * mid - 1;
      lhs = odd * odd * s;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (mag == 0) lo = 0;
    return (c < 0) ? OW'(-lo) : OW'(lo);
  endfunction

  function automatic normal_t face_normal(input coord_t v [9]);
    longint e1 [3], e2 [3], c [3];
    logic [127:0] s, sq;
    normal_t r;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(v[6+i]) - longint'(v[i]);
      e2[i] = longint'(v[3+i]) - longint'(v[i]);
    end
    for (int i = 0; i < 3; i++) begin
      c[i] = e1[(i+1)%3] * e2[(i+2)%3] - e1[(i+2)%3] * e2[(i+1)%3];
      sq = (c[i] < 0) ? -c[i] : c[i];
      s = s + sq * sq;
    end
    if (s == 0) begin
      r = '{nx: '0, ny: '0, nz: '0, deg: 1'b1};
    end else begin
      r.nx = scaled_component(c[0], s);
      r.ny = scaled_component(c[1], s);
      r.nz = scaled_component(c[2], s);
      r.deg = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      normals_seen++;
      if (out_degenerate) degenerate_seen++;
      if (expected_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        normal_t e;
        e = expected_normals.pop_front();
        if (out_normal_x !== e.nx || out_normal_y !== e.ny || out_normal_z !== e.nz ||
            out_degenerate !== e.deg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp %h %h %h deg %b, got %h %h %h deg %b", $realtime,
                     e.nx, e.ny, e.nz, e.deg, out_normal_x, out_normal_y, out_normal_z,
                     out_degenerate);
        end
      end
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= receiver_idle_pct);

  task automatic send_triangle(input coord_t v [9], input bit known, input normal_t res);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) in_v[i] <= v[i];
    do @(posedge clk); while (!in_ready);
    expected_normals.push_back(known ? res : face_normal(v));
    triangles_sent++;
  endtask

  task automatic random_triangle(output coord_t v [9]);
    int kind, k;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) v[i] = coord_t'($urandom);
    if (kind < 3) begin
      for (int i = 3; i < 9; i++) v[i] = v[i%3] + coord_t'($signed($urandom_range(64)) - 32);
    end else if (kind == 3) begin
      k = $signed($urandom_range(6)) - 3;
      for (int i = 0; i < 3; i++) begin
        v[i] = coord_t'($signed($urandom_range(2000)) - 1000);
        v[3+i] = v[i] + coord_t'($signed($urandom_range(200)) - 100);
        v[6+i] = v[i] + coord_t'(k * (v[3+i] - v[i]));
      end
    end else if (kind == 4) begin
      for (int i = 0; i < 9; i++) v[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end
  endtask

  dir_row_t directed [] = '{
    '{'{0,0,0, 0,0,0, 0,0,0}, 1, '{0, 0, 0, 1}},
    '{'{0,0,0, 0,1,0, 1,0,0}, 1, '{0, 0, 16'sd16384, 0}},
    '{'{0,0,0, 1,0,0, 0,1,0}, 1, '{0, 0, -16'sd16384, 0}},
    '{'{0,0,0, 0,0,1, 0,1,0}, 1, '{16'sd16384, 0, 0, 0}},
    '{'{0,0,0, 1,0,0, 0,0,1}, 1, '{0, 16'sd16384, 0, 0}},
    '{'{5,5,5, 5,5,5, 9,9,9}, 1, '{0, 0, 0, 1}},
    '{'{1,2,3, 2,4,6, 3,6,9}, 1, '{0, 0, 0, 1}},
    '{'{-32768,-32768,-32768, 32767,-32768,-32768, -32768,32767,-32768}, 0, '{0,0,0,0}},
    '{'{32767,32767,32767, -32768,32767,32767, 32767,-32768,32767}, 0, '{0,0,0,0}},
    '{'{-32768,32767,-32768, 32767,-32768,32767, 32767,32767,-32768}, 0, '{0,0,0,0}},
    '{'{32767,-32768,0, -32768,0,32767, 0,32767,-32768}, 0, '{0,0,0,0}},
    '{'{0,0,0, 1,1,0, 1,0,1}, 0, '{0,0,0,0}},
    '{'{0,0,0, 1,2,0, 2,0,1}, 0, '{0,0,0,0}},
    '{'{0,0,0, 3,0,0, 0,4,0}, 0, '{0,0,0,0}},
    '{'{-1,-1,-1, 0,-1,-1, -1,0,-1}, 0, '{0,0,0,0}},
    '{'{100,-200,300, -400,500,-600, 700,-800,900}, 0, '{0,0,0,0}},
    '{'{-32768,0,0, 32767,0,0, 0,0,0}, 1, '{0, 0, 0, 1}},
    '{'{0,0,0, 1,1,1, 1,1,2}, 0, '{0,0,0,0}}
  };

  initial begin
    coord_t v [9];
    normal_t none;
    none = '{0, 0, 0, 0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[r]) send_triangle(directed[r].v, directed[r].known, directed[r].res);
    in_valid <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 72 : 0;
      receiver_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 18 : 0;
      repeat (500) begin
        random_triangle(v);
        send_triangle(v, 0, none);
      end
    end
    in_valid <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("%0d triangles sent, %0d normals checked, %0d degenerate, %0d mismatches",
             triangles_sent, normals_seen, degenerate_seen, mismatches);
    if (mismatches == 0 && expected_normals.size() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("testbench failed");
    $finish;
  end
endmodule
